/* design/priority_ready_queue_scheduler_macros.svh */
// Assertion macros shared by the scheduler modules.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PRQS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PRQS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/prqs_pkg.sv */
// Types, codes and helper functions shared by the scheduler modules.
`timescale 1ns / 1ps
package prqs_pkg;

  localparam int LVL_W = 5;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_ENQUEUE = 3'd0;
  localparam mode_t MODE_REMOVE  = 3'd1;
  localparam mode_t MODE_RESCHED = 3'd2;
  localparam mode_t MODE_YIELD   = 3'd3;
  localparam mode_t MODE_LOCK    = 3'd4;
  localparam mode_t MODE_UNLOCK  = 3'd5;
  localparam mode_t MODE_CHPRIO  = 3'd6;

  typedef logic [3:0] cmd_op_t;
  localparam cmd_op_t CMD_NONE     = 4'd0;
  localparam cmd_op_t CMD_CAPTURE  = 4'd1;
  localparam cmd_op_t CMD_OP_TID   = 4'd2;
  localparam cmd_op_t CMD_OP_CUR   = 4'd3;
  localparam cmd_op_t CMD_OP_HEAD  = 4'd4;
  localparam cmd_op_t CMD_READ     = 4'd5;
  localparam cmd_op_t CMD_UNLINK   = 4'd6;
  localparam cmd_op_t CMD_LINK1    = 4'd7;
  localparam cmd_op_t CMD_LINK2    = 4'd8;
  localparam cmd_op_t CMD_LOCK     = 4'd9;
  localparam cmd_op_t CMD_UNLOCK   = 4'd10;
  localparam cmd_op_t CMD_ERROR    = 4'd11;
  localparam cmd_op_t CMD_IDLE     = 4'd12;
  localparam cmd_op_t CMD_LOAD_OUT = 4'd13;

  typedef struct packed {
    cmd_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  tid_ok;
    logic  tid_queued;
    logic  preq_ok;
    logic  cur_valid;
    logic  cur_running;
    logic  cur_ok;
    logic  cur_queued;
    logic  hint;
    logic  locked;
    logic  ready_empty;
    logic  keep_current;
    logic  level_same;
    logic  out_busy;
  } dp_status_t;

  // Count of leading zeros of a 32-bit level bitmap, 32 when empty.
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!hit && v[31-i]) begin
        n   = 6'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* design/prqs_ctrl.sv */
// Sequencing state machine for the scheduler operations.
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_macros.svh"
module prqs_ctrl
  import prqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_SEL    = 4'd2;
  localparam logic [3:0] ST_RD     = 4'd3;
  localparam logic [3:0] ST_UNL    = 4'd4;
  localparam logic [3:0] ST_LINK1  = 4'd5;
  localparam logic [3:0] ST_LINK2  = 4'd6;
  localparam logic [3:0] ST_DONE   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       chg_r, chg_nxt;
  logic       sel_r, sel_nxt;
  logic       run_cur;
  logic       is_yield;

  assign in_stall = (state_r != ST_IDLE);
  assign run_cur  = st.cur_valid && st.cur_running;
  assign is_yield = (st.mode == MODE_YIELD);

  always_comb begin
    state_nxt = state_r;
    chg_nxt   = chg_r;
    sel_nxt   = sel_r;
    cmd.op    = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_CAPTURE;
          state_nxt = ST_DECODE;
          chg_nxt   = 1'b0;
          sel_nxt   = 1'b0;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        case (st.mode)
          MODE_ENQUEUE: begin
            if (!st.tid_ok || st.tid_queued || !st.preq_ok) begin
              cmd.op = CMD_ERROR;
            end else begin
              cmd.op    = CMD_OP_TID;
              state_nxt = ST_LINK1;
            end
          end
          MODE_REMOVE: begin
            if (!st.tid_ok || !st.tid_queued) begin
              cmd.op = CMD_ERROR;
            end else begin
              cmd.op    = CMD_OP_TID;
              state_nxt = ST_RD;
            end
          end
          MODE_RESCHED, MODE_YIELD: begin
            if (!((is_yield || st.hint) && !st.locked)) begin
              state_nxt = ST_DONE;
            end else if (run_cur && !is_yield && st.keep_current) begin
              state_nxt = ST_DONE;
            end else if (run_cur && st.cur_ok && !st.cur_queued) begin
              cmd.op    = CMD_OP_CUR;
              sel_nxt   = 1'b1;
              state_nxt = ST_LINK1;
            end else begin
              state_nxt = ST_SEL;
            end
          end
          MODE_LOCK:   cmd.op = CMD_LOCK;
          MODE_UNLOCK: cmd.op = CMD_UNLOCK;
          MODE_CHPRIO: begin
            if (st.tid_ok && st.tid_queued && st.preq_ok) begin
              cmd.op    = CMD_OP_TID;
              chg_nxt   = 1'b1;
              state_nxt = ST_RD;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SEL: begin
        if (st.ready_empty) begin
          cmd.op    = CMD_IDLE;
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = CMD_OP_HEAD;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.op    = CMD_READ;
        state_nxt = ST_UNL;
      end
      ST_UNL: begin
        if (chg_r && st.level_same) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = CMD_UNLINK;
          state_nxt = chg_r ? ST_LINK1 : ST_DONE;
        end
      end
      ST_LINK1: begin
        cmd.op    = CMD_LINK1;
        state_nxt = ST_LINK2;
      end
      ST_LINK2: begin
        cmd.op    = CMD_LINK2;
        state_nxt = sel_r ? ST_SEL : ST_DONE;
        sel_nxt   = 1'b0;
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.op    = CMD_LOAD_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chg_r   <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chg_r   <= chg_nxt;
      sel_r   <= sel_nxt;
    end
  end

  `PRQS_ASSERT_NOW(a_capture_only_idle, clk, rst_n, cmd.op == CMD_CAPTURE, state_r == ST_IDLE, "capture outside idle")
  `PRQS_ASSERT_NEXT(a_link1_then_link2, clk, rst_n, cmd.op == CMD_LINK1, cmd.op == CMD_LINK2, "link sequence broken")
  `PRQS_ASSERT_NEXT(a_read_then_unl, clk, rst_n, cmd.op == CMD_READ, state_r == ST_UNL, "read not followed by unlink step")

endmodule

/* design/prqs_datapath.sv */
// Queue storage, link memories, lock count and result register of the scheduler.
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_macros.svh"
module prqs_datapath
  import prqs_pkg::*;
#(
  parameter int MAX_THREADS     = 64,
  parameter int PRIORITY_LEVELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_status_t        st,
  input  logic [2:0]        in_mode,
  input  logic [5:0]        in_thread_id,
  input  logic [4:0]        in_priority_req,
  input  logic              in_current_valid,
  input  logic              in_current_running,
  input  logic [5:0]        in_current_id,
  input  logic [4:0]        in_current_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_switched,
  output logic [5:0]        out_chosen_id,
  output logic [4:0]        out_chosen_priority,
  output logic              out_requeued_current,
  output logic              out_idle,
  output logic signed [7:0] out_old_lock_count,
  output logic [31:0]       out_ready_mask,
  output logic              out_error
);

  localparam int TW  = $clog2(MAX_THREADS);
  localparam int LKW = TW + 1;
  localparam int LVW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [LKW-1:0] NIL = {1'b1, {TW{1'b0}}};

  // Captured transaction.
  logic [2:0]       mode_r;
  logic [5:0]       tid_r;
  logic [4:0]       preq_r;
  logic             cvalid_r, crun_r;
  logic [5:0]       cid_r;
  logic [4:0]       cprio_r;

  // Scheduler state.
  logic [31:0]            ready_r;
  logic                   hint_r;
  logic signed [7:0]      lock_r;
  logic [MAX_THREADS-1:0] queued_r;
  logic [LKW-1:0]         head_r [PRIORITY_LEVELS];
  logic [LKW-1:0]         tail_r [PRIORITY_LEVELS];

  // Link memories.
  logic [LKW-1:0]   next_mem [MAX_THREADS];
  logic [LKW-1:0]   prev_mem [MAX_THREADS];
  logic [LVL_W-1:0] lvl_mem  [MAX_THREADS];
  logic [LKW-1:0]   rd_next_r, rd_prev_r;
  logic [LVL_W-1:0] rd_lvl_r;

  // Operand and partial result.
  logic [TW-1:0]    op_thr_r;
  logic [LVL_W-1:0] op_lv_r;
  logic             sw_r, req_r, idle_r, err_r;
  logic [5:0]       chid_r;
  logic [4:0]       chpr_r;
  logic signed [7:0] oldlk_r;
  logic             out_valid_r;

  logic [TW-1:0]    tid_idx, cid_idx;
  logic [5:0]       lz;
  logic [LVL_W-1:0] top_lv, cur_lv;
  logic [LVW-1:0]   op_li, rd_li, top_li;

  // Memory write ports.
  logic             nx_we, pv_we, lv_we;
  logic [TW-1:0]    nx_wa, pv_wa, lv_wa;
  logic [LKW-1:0]   nx_wd, pv_wd;
  logic [LVL_W-1:0] lv_wd;

  assign tid_idx = TW'(tid_r);
  assign cid_idx = TW'(cid_r);
  assign lz      = lzc32(ready_r);
  assign top_lv  = lz[4:0];
  assign cur_lv  = (32'(cprio_r) >= 32'(PRIORITY_LEVELS)) ?
                   LVL_W'(PRIORITY_LEVELS - 1) : cprio_r;
  assign op_li   = LVW'(op_lv_r);
  assign rd_li   = LVW'(rd_lvl_r);
  assign top_li  = LVW'(top_lv);

  always_comb begin
    st.mode         = mode_r;
    st.tid_ok       = 32'(tid_r) < 32'(MAX_THREADS);
    st.tid_queued   = st.tid_ok && queued_r[tid_idx];
    st.preq_ok      = 32'(preq_r) < 32'(PRIORITY_LEVELS);
    st.cur_valid    = cvalid_r;
    st.cur_running  = crun_r;
    st.cur_ok       = 32'(cid_r) < 32'(MAX_THREADS);
    st.cur_queued   = st.cur_ok && queued_r[cid_idx];
    st.hint         = hint_r;
    st.locked       = lock_r > 8'sd0;
    st.ready_empty  = (ready_r == 32'd0);
    st.keep_current = {1'b0, cprio_r} <= lz;
    st.level_same   = (rd_lvl_r == preq_r);
    st.out_busy     = out_valid_r && out_stall;
  end

  always_comb begin
    nx_we = 1'b0; nx_wa = op_thr_r; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = op_thr_r; pv_wd = NIL;
    lv_we = 1'b0; lv_wa = op_thr_r; lv_wd = op_lv_r;
    case (cmd.op)
      CMD_UNLINK: begin
        // Bridge the neighbors of the thread around it.
        pv_we = !rd_next_r[TW];
        pv_wa = rd_next_r[TW-1:0];
        pv_wd = rd_prev_r;
        nx_we = !rd_prev_r[TW];
        nx_wa = rd_prev_r[TW-1:0];
        nx_wd = rd_next_r;
      end
      CMD_LINK1: begin
        nx_we = ready_r[~op_lv_r];
        nx_wa = tail_r[op_li][TW-1:0];
        nx_wd = {1'b0, op_thr_r};
        pv_we = 1'b1;
        pv_wd = ready_r[~op_lv_r] ? tail_r[op_li] : NIL;
        lv_we = 1'b1;
      end
      CMD_LINK2: nx_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd.op == CMD_READ) rd_next_r <= next_mem[op_thr_r];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd.op == CMD_READ) rd_prev_r <= prev_mem[op_thr_r];
  end

  always_ff @(posedge clk) begin
    if (lv_we) lvl_mem[lv_wa] <= lv_wd;
    if (cmd.op == CMD_READ) rd_lvl_r <= lvl_mem[op_thr_r];
  end

  // Payload registers: heads, tails, operands and captured fields.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_CAPTURE: begin
        mode_r   <= in_mode;
        tid_r    <= in_thread_id;
        preq_r   <= in_priority_req;
        cvalid_r <= in_current_valid;
        crun_r   <= in_current_running;
        cid_r    <= in_current_id;
        cprio_r  <= in_current_priority;
      end
      CMD_OP_TID: begin
        op_thr_r <= tid_idx;
        op_lv_r  <= preq_r;
      end
      CMD_OP_CUR: begin
        op_thr_r <= cid_idx;
        op_lv_r  <= cur_lv;
      end
      CMD_OP_HEAD: begin
        op_thr_r <= head_r[top_li][TW-1:0];
        op_lv_r  <= top_lv;
        chid_r   <= 6'(head_r[top_li][TW-1:0]);
        chpr_r   <= top_lv;
      end
      CMD_UNLINK: begin
        if (rd_next_r[TW]) tail_r[rd_li] <= rd_prev_r;
        if (rd_prev_r[TW]) head_r[rd_li] <= rd_next_r;
      end
      CMD_LINK1: begin
        if (!ready_r[~op_lv_r]) head_r[op_li] <= {1'b0, op_thr_r};
        tail_r[op_li] <= {1'b0, op_thr_r};
      end
      default: ;
    endcase
  end

  // Control state and result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= '0;
      hint_r      <= 1'b0;
      lock_r      <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
      sw_r        <= 1'b0;
      req_r       <= 1'b0;
      idle_r      <= 1'b0;
      err_r       <= 1'b0;
      oldlk_r     <= '0;
    end else begin
      if (cmd.op == CMD_LOAD_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        CMD_CAPTURE: begin
          sw_r    <= 1'b0;
          req_r   <= 1'b0;
          idle_r  <= 1'b0;
          err_r   <= 1'b0;
          oldlk_r <= '0;
        end
        CMD_OP_CUR:  req_r <= 1'b1;
        CMD_OP_HEAD: begin
          sw_r   <= 1'b1;
          hint_r <= 1'b0;
        end
        CMD_UNLINK: begin
          queued_r[op_thr_r] <= 1'b0;
          if ((rd_prev_r[TW] ? rd_next_r[TW] : head_r[rd_li][TW]))
            ready_r[~rd_lvl_r] <= 1'b0;
        end
        CMD_LINK1: begin
          queued_r[op_thr_r] <= 1'b1;
          ready_r[~op_lv_r]  <= 1'b1;
          hint_r             <= 1'b1;
        end
        CMD_LOCK: begin
          oldlk_r <= lock_r;
          if (lock_r != 8'sd127) lock_r <= lock_r + 8'sd1;
        end
        CMD_UNLOCK: begin
          oldlk_r <= lock_r;
          if (lock_r != -8'sd128) lock_r <= lock_r - 8'sd1;
        end
        CMD_ERROR: err_r  <= 1'b1;
        CMD_IDLE:  idle_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD_OUT) begin
      out_switched         <= sw_r;
      out_chosen_id        <= sw_r ? chid_r : 6'd0;
      out_chosen_priority  <= sw_r ? chpr_r : 5'd0;
      out_requeued_current <= req_r;
      out_idle             <= idle_r;
      out_old_lock_count   <= oldlk_r;
      out_ready_mask       <= ready_r;
      out_error            <= err_r;
    end
  end

  assign out_valid = out_valid_r;

  `PRQS_ASSERT_NOW(a_link_unqueued, clk, rst_n, cmd.op == CMD_LINK1, !queued_r[op_thr_r], "linking a queued thread")
  `PRQS_ASSERT_NOW(a_unlink_queued, clk, rst_n, cmd.op == CMD_UNLINK, queued_r[op_thr_r], "unlinking an unqueued thread")
  `PRQS_ASSERT_NOW(a_load_free, clk, rst_n, cmd.op == CMD_LOAD_OUT, !(out_valid_r && out_stall), "result overwritten")
  `PRQS_ASSERT_NEXT(a_pop_clears_hint, clk, rst_n, cmd.op == CMD_OP_HEAD, !hint_r, "hint not cleared on pop")

endmodule

/* design/priority_ready_queue_scheduler.sv */
// Top level of the bitmap priority ready-queue scheduler.
`timescale 1ns / 1ps
// The scheduler keeps one FIFO ready queue per priority level (level 0 is
// the highest) as doubly linked lists in on-chip link memories, plus a
// bitmap of non-empty levels, a reschedule hint and a saturating lock count.
// Each input transaction carries one operation and produces exactly one
// result transaction. Operations are handled one at a time by a sequencer
// that walks the link memories, whose reads are registered. A result waits
// in an output register while the next transaction is accepted. No clearing
// pass is needed after reset: the link memories are only read for queued
// threads.
module priority_ready_queue_scheduler
  import prqs_pkg::*;
#(
  parameter int MAX_THREADS     = 64,
  parameter int PRIORITY_LEVELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_mode,
  input  logic [5:0]        in_thread_id,
  input  logic [4:0]        in_priority_req,
  input  logic              in_current_valid,
  input  logic              in_current_running,
  input  logic [5:0]        in_current_id,
  input  logic [4:0]        in_current_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_switched,
  output logic [5:0]        out_chosen_id,
  output logic [4:0]        out_chosen_priority,
  output logic              out_requeued_current,
  output logic              out_idle,
  output logic signed [7:0] out_old_lock_count,
  output logic [31:0]       out_ready_mask,
  output logic              out_error
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // The controller accepts a transaction only when it has no work pending.
  prqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns all queue state and the result register.
  prqs_datapath #(
    .MAX_THREADS     (MAX_THREADS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_mode              (in_mode),
    .in_thread_id         (in_thread_id),
    .in_priority_req      (in_priority_req),
    .in_current_valid     (in_current_valid),
    .in_current_running   (in_current_running),
    .in_current_id        (in_current_id),
    .in_current_priority  (in_current_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_switched         (out_switched),
    .out_chosen_id        (out_chosen_id),
    .out_chosen_priority  (out_chosen_priority),
    .out_requeued_current (out_requeued_current),
    .out_idle             (out_idle),
    .out_old_lock_count   (out_old_lock_count),
    .out_ready_mask       (out_ready_mask),
    .out_error            (out_error)
  );

endmodule
